@@ rtl/lis_pkg.sv @@
// Shared constants and types for the increasing-run length block.
package lis_pkg;

    localparam int MAX_LEN     = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int SAMPLE_W    = 32;
    localparam int RUN_W       = 7;
    localparam int RUN_MAX     = (1 << RUN_W) - 1;
    localparam int COUNT_W     = $clog2(MAX_LEN + 1);
    localparam int LEN_W       = (COUNT_W > RUN_W) ? COUNT_W : RUN_W;

    typedef logic signed [VALUE_WIDTH-1:0] tail_t;
    typedef logic [COUNT_W-1:0]            count_t;

    // Per-cell status handed to the neighbor and to the top level.
    typedef struct packed {
        logic pass;    // cell holds a tail below the key
        logic write;   // cell takes the key this cycle
        logic append;  // cell takes the key as a new tail
    } cell_stat_t;

endpackage

@@ rtl/longest_increasing_subsequence_length_top.sv @@
// Longest strictly increasing subsequence length, chain of tail cells.
// The result is registered when the item is accepted.
// Throughput: one item per cycle while the receiver takes each result; all cells compare the key in parallel and
// the first non-passing cell takes it in the same cycle.
// Reset: synchronous active-low aresetn clears the fill count and the output
// valid flag; tails and result data are not cleared, tails are only read below the fill count.
module longest_increasing_subsequence_length_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [lis_pkg::SAMPLE_W-1:0]   s_sample_value,
    input  logic                           s_start_sequence,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [lis_pkg::RUN_W-1:0]      m_run_length,
    output logic                           m_overflow
);

    lis_pkg::count_t                   fill_reg;
    lis_pkg::count_t                   fill_next;
    lis_pkg::count_t                   fill_eff;
    logic                              m_valid_reg;
    logic                              m_valid_next;
    logic [lis_pkg::RUN_W-1:0]         run_reg;
    logic [lis_pkg::RUN_W-1:0]         run_next;
    logic                              ovf_reg;
    logic                              ovf_next;
    logic                              in_accept;
    lis_pkg::tail_t                    key;
    lis_pkg::cell_stat_t               stat [lis_pkg::MAX_LEN];
    logic [lis_pkg::MAX_LEN-1:0]       append_vec;
    logic [lis_pkg::MAX_LEN-1:0]       write_vec;
    logic                              grow;
    logic [lis_pkg::LEN_W-1:0]         fill_wide;

    assign s_ready   = !m_valid_reg || m_ready;
    assign in_accept = s_valid && s_ready;
    assign key       = lis_pkg::VALUE_WIDTH'($signed(s_sample_value));
    assign fill_eff  = s_start_sequence ? '0 : fill_reg;

    for (genvar i = 0; i < lis_pkg::MAX_LEN; i++) begin : g_cell
        logic prev_pass;
        logic valid;

        if (i == 0) begin : g_head
            assign prev_pass = 1'b1;
        end else begin : g_link
            assign prev_pass = stat[i-1].pass;
        end

        assign valid = lis_pkg::COUNT_W'(i) < fill_eff;

        lis_cell u_cell (
            .aclk      (aclk),
            .upd       (in_accept),
            .key       (key),
            .valid     (valid),
            .prev_pass (prev_pass),
            .stat      (stat[i])
        );

        assign append_vec[i] = stat[i].append;
        assign write_vec[i]  = stat[i].write;
    end

    // Every cell passes only when the store is full and the key is above all.
    assign ovf_next  = stat[lis_pkg::MAX_LEN-1].pass;
    assign grow      = |append_vec;
    assign fill_next = in_accept ? fill_eff + lis_pkg::COUNT_W'(grow) : fill_reg;
    assign fill_wide = lis_pkg::LEN_W'(fill_next);

    always_comb begin
        m_valid_next = m_valid_reg;
        run_next     = run_reg;
        if (in_accept) begin
            m_valid_next = 1'b1;
            if (fill_wide > lis_pkg::LEN_W'(lis_pkg::RUN_MAX)) begin
                run_next = lis_pkg::RUN_W'(lis_pkg::RUN_MAX);
            end else begin
                run_next = fill_wide[lis_pkg::RUN_W-1:0];
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            run_reg <= run_next;
            ovf_reg <= ovf_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_run_length = run_reg;
    assign m_overflow   = ovf_reg;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= lis_pkg::COUNT_W'(lis_pkg::MAX_LEN))
        else $error("fill count above store depth");

    a_one_writer: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept && !ovf_next |-> $onehot(write_vec))
        else $error("not exactly one cell takes the key");

    a_ovf_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept && ovf_next |-> write_vec == '0)
        else $error("cell written on dropped append");

    a_ovf_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && ovf_reg |-> fill_reg == lis_pkg::COUNT_W'(lis_pkg::MAX_LEN))
        else $error("overflow reported with store not full");

    a_fill_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept && !s_start_sequence |=> fill_reg >= $past(fill_reg))
        else $error("fill count shrank without start");

endmodule

@@ rtl/lis_cell.sv @@
// One cell of the tails chain: holds one tail and compares it with the key.
module lis_cell (
    input  logic                 aclk,
    input  logic                 upd,
    input  lis_pkg::tail_t       key,
    input  logic                 valid,
    input  logic                 prev_pass,
    output lis_pkg::cell_stat_t  stat
);

    lis_pkg::tail_t tail_reg;
    lis_pkg::tail_t tail_next;
    logic           pass;
    logic           take;

    // The valid prefix is sorted, so pass is monotone along the chain and the
    // first cell that does not pass is the only one with a passing neighbor.
    assign pass = valid && (tail_reg < key);
    assign take = prev_pass && !pass;

    assign stat.pass   = pass;
    assign stat.write  = take;
    assign stat.append = take && !valid;

    always_comb begin
        tail_next = tail_reg;
        if (upd && take) begin
            tail_next = key;
        end
    end

    always_ff @(posedge aclk) begin
        tail_reg <= tail_next;
    end

endmodule

@@ tb/tb_longest_increasing_subsequence_length_top.sv @@
// Self-checking testbench for the increasing-run length block: directed table, random sequences.
module tb_longest_increasing_subsequence_length_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 950;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int REPORT_MAX   = 10;
    localparam int HOLD_CYCLES  = 200;

    typedef struct packed {
        logic [lis_pkg::RUN_W-1:0] run_length;
        logic                      overflow;
    } run_result_t;

    typedef struct packed {
        logic [lis_pkg::SAMPLE_W-1:0] value;
        logic                         start;
        logic                         typed;
        logic [lis_pkg::RUN_W-1:0]    run_length;
        logic                         overflow;
    } stim_row_t;

    localparam int DIRECTED_N = 20;
    // Rows with typed set carry an expectation that is obvious by hand.
    localparam stim_row_t DIRECTED_ROWS [DIRECTED_N] = '{
        '{32'h0000_0000, 1'b0, 1'b1, 7'd1, 1'b0},
        '{32'h8000_0000, 1'b0, 1'b1, 7'd1, 1'b0},
        '{32'h7fff_ffff, 1'b0, 1'b1, 7'd2, 1'b0},
        '{32'h7fff_ffff, 1'b0, 1'b1, 7'd2, 1'b0},
        '{32'h0000_0005, 1'b0, 1'b0, 7'd0, 1'b0},
        '{32'h0000_0005, 1'b0, 1'b0, 7'd0, 1'b0},
        '{32'h0000_0006, 1'b0, 1'b0, 7'd0, 1'b0},
        '{32'hffff_ffff, 1'b1, 1'b1, 7'd1, 1'b0},
        '{32'hffff_fffe, 1'b0, 1'b1, 7'd1, 1'b0},
        '{32'h8000_0000, 1'b0, 1'b1, 7'd1, 1'b0},
        '{32'h8000_0001, 1'b0, 1'b1, 7'd2, 1'b0},
        '{32'h8000_0001, 1'b0, 1'b0, 7'd0, 1'b0},
        '{32'h0000_0000, 1'b0, 1'b0, 7'd0, 1'b0},
        '{32'h5555_5555, 1'b0, 1'b0, 7'd0, 1'b0},
        '{32'haaaa_aaaa, 1'b0, 1'b0, 7'd0, 1'b0},
        '{32'h7fff_fffe, 1'b0, 1'b0, 7'd0, 1'b0},
        '{32'h7fff_ffff, 1'b0, 1'b0, 7'd0, 1'b0},
        '{32'h7fff_ffff, 1'b1, 1'b1, 7'd1, 1'b0},
        '{32'h8000_0000, 1'b1, 1'b1, 7'd1, 1'b0},
        '{32'h8000_0000, 1'b0, 1'b1, 7'd1, 1'b0}
    };

    logic                         aclk;
    logic                         aresetn;
    logic                         s_valid;
    logic                         s_ready;
    logic [lis_pkg::SAMPLE_W-1:0] s_sample_value;
    logic                         s_start_sequence;
    logic                         m_valid;
    logic                         m_ready;
    logic [lis_pkg::RUN_W-1:0]    m_run_length;
    logic                         m_overflow;

    lis_pkg::tail_t tails [lis_pkg::MAX_LEN];
    int             tail_count;
    run_result_t    expected_runs [$];
    int             fail_count;
    int             report_count;
    int             cycle_count;
    bit             quiet;
    bit             hold_req;

    longest_increasing_subsequence_length_top u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_sample_value   (s_sample_value),
        .s_start_sequence (s_start_sequence),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_run_length     (m_run_length),
        .m_overflow       (m_overflow)
    );

    initial begin
        aclk             = 1'b0;
        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_sample_value   = '0;
        s_start_sequence = 1'b0;
        m_ready          = 1'b0;
        tail_count       = 0;
        fail_count       = 0;
        report_count     = 0;
        cycle_count      = 0;
        quiet            = 1'b0;
        hold_req         = 1'b0;
    end

    always #5 aclk = ~aclk;

    // Patience update: replace the first tail not below the value, else append.
    function automatic run_result_t lis_update(logic [lis_pkg::SAMPLE_W-1:0] sample,
                                               logic start);
        lis_pkg::tail_t v;
        int             pos;
        run_result_t    r;
        v = sample[lis_pkg::VALUE_WIDTH-1:0];
        if (start) tail_count = 0;
        pos = tail_count;
        for (int i = 0; i < tail_count; i++) begin
            if (tails[i] >= v) begin
                pos = i;
                break;
            end
        end
        r.overflow = 1'b0;
        if (pos < tail_count) begin
            tails[pos] = v;
        end else if (tail_count < lis_pkg::MAX_LEN) begin
            tails[tail_count] = v;
            tail_count++;
        end else begin
            r.overflow = 1'b1;
        end
        r.run_length = (tail_count > lis_pkg::RUN_MAX) ?
                       lis_pkg::RUN_W'(lis_pkg::RUN_MAX) : lis_pkg::RUN_W'(tail_count);
        return r;
    endfunction

    // Offer one item after a random gap and hold it until accepted.
    task automatic send_item(logic [lis_pkg::SAMPLE_W-1:0] value, logic start, logic typed,
                             logic [lis_pkg::RUN_W-1:0] run_length, logic overflow);
        int          gap;
        run_result_t r;
        gap = 0;
        if (!quiet) begin
            while ($urandom_range(99) < 26) gap++;
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        r = lis_update(value, start);
        if (typed) begin
            r.run_length = run_length;
            r.overflow   = overflow;
        end
        expected_runs.push_back(r);
        s_valid          <= 1'b1;
        s_sample_value   <= value;
        s_start_sequence <= start;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Receiver: random back-pressure, plus one long hold-off on request.
    always @(posedge aclk) begin
        int hold_left;
        bit hold_seen;
        if (hold_req && !hold_seen) begin
            hold_seen = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (quiet) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= 26);
        end
    end

    always @(posedge aclk) begin
        run_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_runs.size() == 0) begin
                fail_count++;
                if (report_count < REPORT_MAX) begin
                    $display("unexpected result: run_length=%0d overflow=%0b",
                             m_run_length, m_overflow);
                end
                report_count++;
            end else begin
                want = expected_runs.pop_front();
                if (m_run_length !== want.run_length || m_overflow !== want.overflow) begin
                    fail_count++;
                    if (report_count < REPORT_MAX) begin
                        $display({"mismatch: run_length exp=%0d got=%0d, ",
                                  "overflow exp=%0b got=%0b"},
                                 want.run_length, m_run_length, want.overflow, m_overflow);
                    end
                    report_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL longest_increasing_subsequence_length_top");
            $finish;
        end
    end

    initial begin
        int                           sent;
        int                           mode;
        int                           seq_len;
        logic                         first_start;
        logic                         st;
        logic [lis_pkg::SAMPLE_W-1:0] v;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIRECTED_N; i++) begin
            send_item(DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].start, DIRECTED_ROWS[i].typed,
                      DIRECTED_ROWS[i].run_length, DIRECTED_ROWS[i].overflow);
        end

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            mode        = $urandom_range(9);
            first_start = ($urandom_range(7) != 0);
            case (mode)
                0, 1, 2, 3: begin
                    seq_len = $urandom_range(40, 100);
                    v       = 32'h8000_0000 + ($urandom >> 2);
                end
                4: begin
                    seq_len = $urandom_range(1, 40);
                    v       = 32'h7fff_ffff - ($urandom >> 2);
                end
                default: begin
                    seq_len = $urandom_range(1, 30);
                    v       = $urandom;
                end
            endcase
            for (int k = 0; k < seq_len && sent < RANDOM_ITEMS; k++) begin
                case (mode)
                    0, 1, 2, 3: begin
                        // Rising run with repeats and small dips; long ones fill the store.
                        if ($urandom_range(9) == 0) v = v - $urandom_range(0, 1000);
                        else if ($urandom_range(7) != 0) v = v + $urandom_range(1, 65535);
                    end
                    4: v = v - $urandom_range(0, 255);
                    5, 6: v = $urandom;
                    7: v = $urandom_range(0, 15) - 8;
                    default: begin
                        case ($urandom_range(4))
                            0: v = 32'h8000_0000;
                            1: v = 32'h7fff_ffff;
                            2: v = 32'hffff_ffff;
                            3: v = 32'h0000_0000;
                            default: v = 32'h0000_0001;
                        endcase
                    end
                endcase
                st    = (k == 0) ? first_start : ($urandom_range(49) == 0);
                quiet = (sent >= 500 && sent < 650);
                if (sent == 300) hold_req = 1'b1;
                send_item(v, st, 1'b0, '0, 1'b0);
                sent++;
            end
        end
        s_valid <= 1'b0;
        quiet = 1'b0;

        while (expected_runs.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (fail_count == 0) begin
            $display("PASS longest_increasing_subsequence_length_top");
        end else begin
            $display("FAIL longest_increasing_subsequence_length_top");
        end
        $finish;
    end

endmodule
